// ===== rtl/ct2u_pkg.sv =====
// shared types, constants and codes for the codepage to utf-8 transcoder
package ct2u_pkg;

  localparam int TABLE_DEPTH   = 256;
  localparam int TABLE_ADDR_W  = 8;
  localparam int CP_W          = 32;
  localparam int IN_TDATA_W    = 48;
  localparam int Q_DEPTH_DEF   = 4;

  // input item kinds carried in tuser
  localparam logic KIND_DATA     = 1'b0;
  localparam logic KIND_TABLE_WR = 1'b1;

  // mode register codes
  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_PAGE0 = 2'd1;

  localparam logic [CP_W-1:0] CP_MAX_1B = 32'h0000_007F;
  localparam logic [CP_W-1:0] CP_MAX_2B = 32'h0000_07FF;
  localparam logic [CP_W-1:0] CP_MAX_3B = 32'h0000_FFFF;
  localparam logic [CP_W-1:0] CP_MAX    = 32'h0010_FFFF;

  localparam logic [7:0] LEAD_2B = 8'hC0;
  localparam logic [7:0] LEAD_3B = 8'hE0;
  localparam logic [7:0] LEAD_4B = 8'hF0;
  localparam logic [7:0] CONT    = 8'h80;
  localparam logic [5:0] CONT_MASK = 6'h3F;
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // one encoded run: up to four bytes, first byte in the low bits
  typedef struct packed {
    logic       buf_end;
    logic [1:0] n_minus1;
    logic [31:0] bytes;
  } q_entry_t;

  // queue status seen by the front end
  typedef struct packed {
    logic       full;
    logic       nearly_full;
  } q_status_t;

endpackage

// ===== rtl/ct2u_ram.sv =====
// generic simple dual-port ram with registered read
module ct2u_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/ct2u_front.sv =====
// front end: accepts items, writes the code table, looks up and encodes bytes
module ct2u_front import ct2u_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            mode,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  input  q_status_t             q_stat,
  output logic                  push,
  output q_entry_t              push_entry
);

  logic                    accept;
  logic                    acc_data;
  logic [7:0]              data_byte;
  logic [TABLE_ADDR_W-1:0] entry_index;
  logic [CP_W-1:0]         entry_value;
  logic [TABLE_ADDR_W-1:0] rd_slot;
  logic [CP_W-1:0]         cp;

  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_pass_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  assign data_byte   = in_tdata[7:0];
  assign entry_index = in_tdata[15:8];
  assign entry_value = in_tdata[47:16];

  // room for the item in flight plus the new one
  assign in_tready = !q_stat.full && !(q_stat.nearly_full && s1_valid_r);
  assign accept    = in_tvalid && in_tready;
  assign acc_data  = accept && (in_tuser == KIND_DATA);

  // mode three selects the second page too
  assign rd_slot = {mode[1], data_byte[6:0]};

  ct2u_ram #(
    .WIDTH (CP_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (accept && (in_tuser == KIND_TABLE_WR)),
    .wr_addr (entry_index),
    .wr_data (entry_value),
    .rd_en   (acc_data),
    .rd_addr (rd_slot),
    .rd_data (cp)
  );

  assign s1_valid_nxt = acc_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_data) begin
      s1_pass_r <= (mode == MODE_PASS) || !data_byte[7];
      s1_byte_r <= data_byte;
      s1_end_r  <= in_tlast;
    end
  end

  always_comb begin
    push_entry         = '0;
    push_entry.buf_end = s1_end_r;
    if (s1_pass_r) begin
      push_entry.bytes    = {24'd0, s1_byte_r};
      push_entry.n_minus1 = 2'd0;
    end else if (cp == '0 || cp > CP_MAX) begin
      push_entry.bytes    = {8'd0, REPL_B2, REPL_B1, REPL_B0};
      push_entry.n_minus1 = 2'd2;
    end else if (cp <= CP_MAX_1B) begin
      push_entry.bytes    = {24'd0, cp[7:0]};
      push_entry.n_minus1 = 2'd0;
    end else if (cp <= CP_MAX_2B) begin
      push_entry.bytes    = {16'd0, CONT | {2'b00, cp[5:0] & CONT_MASK},
                             LEAD_2B | {3'b000, cp[10:6]}};
      push_entry.n_minus1 = 2'd1;
    end else if (cp <= CP_MAX_3B) begin
      push_entry.bytes    = {8'd0, CONT | {2'b00, cp[5:0]},
                             CONT | {2'b00, cp[11:6]},
                             LEAD_3B | {4'b0000, cp[15:12]}};
      push_entry.n_minus1 = 2'd2;
    end else begin
      push_entry.bytes    = {CONT | {2'b00, cp[5:0]},
                             CONT | {2'b00, cp[11:6]},
                             CONT | {2'b00, cp[17:12]},
                             LEAD_4B | {5'b00000, cp[20:18]}};
      push_entry.n_minus1 = 2'd3;
    end
  end

  assign push = s1_valid_r;

endmodule

// ===== rtl/ct2u_queue.sv =====
// short fifo of encoded runs between front and back end
module ct2u_queue import ct2u_pkg::*; #(
  parameter int DEPTH = Q_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  q_entry_t                   push_entry,
  input  logic                       pop,
  output logic                       not_empty,
  output q_entry_t                   head,
  output q_status_t                  stat,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  q_entry_t entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head             = entries_r[rd_ptr_r];
  assign not_empty        = (count_r != '0);
  assign stat.full        = (count_r == CNT_W'(DEPTH));
  assign stat.nearly_full = (count_r == CNT_W'(DEPTH-1));
  assign count            = count_r;

endmodule

// ===== rtl/ct2u_back.sv =====
// back end: sends one byte of the head run per cycle while the receiver is ready, through an output register
module ct2u_back import ct2u_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     not_empty,
  input  q_entry_t head,
  output logic     pop,
  output logic     out_tvalid,
  input  logic     out_tready,
  output logic [7:0] out_tdata,
  output logic     out_tlast,
  output logic     out_tuser
);

  logic       load;
  logic       at_last;
  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       end_r;
  logic [7:0] sel_byte;

  assign load    = !valid_r || out_tready;
  assign at_last = (idx_r == head.n_minus1);
  assign pop     = load && not_empty && at_last;

  always_comb begin
    unique case (idx_r)
      2'd0: sel_byte = head.bytes[7:0];
      2'd1: sel_byte = head.bytes[15:8];
      2'd2: sel_byte = head.bytes[23:16];
      2'd3: sel_byte = head.bytes[31:24];
      default: sel_byte = head.bytes[7:0];
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = not_empty;
      if (not_empty) begin
        idx_nxt = at_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && not_empty) begin
      byte_r <= sel_byte;
      last_r <= at_last;
      end_r  <= at_last && head.buf_end;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  assign out_tuser  = end_r;

endmodule

// ===== rtl/codepage_to_utf8_transcoder.sv =====
// top level: single-byte codepage to utf-8 transcoder
// data path: front stage register, then the queue, then the back end output register
// throughput: one output byte per cycle while the receiver is ready; an input byte
// expands to 1 to 4 output bytes; a table write gives no output
// reset (synchronous, active low) clears mode, queue and handshake state; the code table
// is not cleared and each entry is undefined until written
module codepage_to_utf8_transcoder import ct2u_pkg::*; #(
  parameter int Q_DEPTH = Q_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_wdata,   // mode
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,    // data_byte, entry_index, entry_value
  input  logic                  in_tuser,    // kind
  input  logic                  in_tlast,    // last_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,   // out_byte
  output logic                  out_tlast,   // last
  output logic                  out_tuser    // buffer_end
);

  logic [1:0] mode_r, mode_nxt;
  logic       push;
  q_entry_t   push_entry;
  logic       pop;
  logic       not_empty;
  q_entry_t   head;
  q_status_t  q_stat;
  logic [$clog2(Q_DEPTH+1)-1:0] q_count;

  assign mode_nxt = cfg_we ? cfg_wdata : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PASS;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  ct2u_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  ct2u_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head),
    .stat       (q_stat),
    .count      (q_count)
  );

  ct2u_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .not_empty  (not_empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // the queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (q_count != ($clog2(Q_DEPTH+1))'(Q_DEPTH)) || pop)
    else $error("code queue overflow");

  // buffer end only on the final byte of a run
  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("buffer end outside final byte");

  // a multi-byte run is sent without gaps
  a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |=> out_tvalid)
    else $error("gap inside utf-8 run");

  // ready is withheld once the queue is full
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_tready)
    else $error("ready with full queue");

endmodule

// ===== tb/tb_codepage_to_utf8_transcoder.sv =====
// testbench for the codepage to utf-8 transcoder: directed code points, random traffic, stalls
`timescale 1ns / 1ps

module tb_codepage_to_utf8_transcoder;
  import ct2u_pkg::*;

  localparam logic [1:0] MODE_PAGE1     = 2'd2;
  localparam logic [1:0] MODE_PAGE1_ALT = 2'd3;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         CYCLE_LIMIT    = 400000;

  typedef struct packed {
    logic [7:0] ubyte;
    logic       run_last;
    logic       buf_end;
  } utf8_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_wdata = 2'd0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;   // data_byte, entry_index, entry_value
  logic                  in_tuser = 1'b0; // kind
  logic                  in_tlast = 1'b0; // last_in
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;       // out_byte
  logic                  out_tlast;       // last
  logic                  out_tuser;       // buffer_end

  // predictor state
  logic [CP_W-1:0] code_points [TABLE_DEPTH];
  bit              slot_written [TABLE_DEPTH];
  logic [1:0]      active_mode = MODE_PASS;
  utf8_byte_t      utf8_expected_q [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  no_gaps = 1'b0;

  codepage_to_utf8_transcoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial forever #2 clk = ~clk;

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [CP_W-1:0] pick_point();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom_range(1, CP_MAX_1B);
      2: return $urandom_range(CP_MAX_1B + 1, CP_MAX_2B);
      3: return $urandom_range(CP_MAX_2B + 1, CP_MAX_3B);
      4: return $urandom_range(32'hD800, 32'hDFFF);
      5: return $urandom_range(CP_MAX_3B + 1, CP_MAX);
      6: return $urandom_range(CP_MAX + 1, 32'hFFFF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TABLE_ADDR_W-1:0] slot_of(input logic [7:0] data_byte);
    // modes 2 and 3 both read the second codepage
    return {active_mode != MODE_PAGE0, data_byte[6:0]};
  endfunction

  task automatic queue_byte(input logic [7:0] ubyte, input logic run_last,
                            input logic buf_end);
    utf8_byte_t item;
    item.ubyte    = ubyte;
    item.run_last = run_last;
    item.buf_end  = buf_end;
    utf8_expected_q = {utf8_expected_q, item};
  endtask

  task automatic expect_code_point(input logic [CP_W-1:0] cp, input logic last_in);
    logic [7:0] b [4];
    int         n;
    if (cp == '0 || cp > CP_MAX) begin
      b[0] = REPL_B0; b[1] = REPL_B1; b[2] = REPL_B2; n = 3;
    end else if (cp <= CP_MAX_1B) begin
      b[0] = cp[7:0]; n = 1;
    end else if (cp <= CP_MAX_2B) begin
      b[0] = LEAD_2B | {3'b000, cp[10:6]};
      b[1] = CONT | {2'b00, cp[5:0]};
      n = 2;
    end else if (cp <= CP_MAX_3B) begin
      b[0] = LEAD_3B | {4'b0000, cp[15:12]};
      b[1] = CONT | {2'b00, cp[11:6]};
      b[2] = CONT | {2'b00, cp[5:0]};
      n = 3;
    end else begin
      b[0] = LEAD_4B | {5'b00000, cp[20:18]};
      b[1] = CONT | {2'b00, cp[17:12]};
      b[2] = CONT | {2'b00, cp[11:6]};
      b[3] = CONT | {2'b00, cp[5:0]};
      n = 4;
    end
    for (int k = 0; k < n; k++)
      queue_byte(b[k], k == n - 1, (k == n - 1) && last_in);
  endtask

  task automatic predict_transcode(input logic kind, input logic [7:0] data_byte,
                                   input logic [7:0] idx, input logic [CP_W-1:0] val,
                                   input logic last_in);
    if (kind == KIND_TABLE_WR) begin
      code_points[idx]  = val;
      slot_written[idx] = 1'b1;
    end else if (active_mode == MODE_PASS || !data_byte[7]) begin
      queue_byte(data_byte, 1'b1, last_in);
    end else begin
      expect_code_point(code_points[slot_of(data_byte)], last_in);
    end
  endtask

  // called at a falling edge, returns at a falling edge with in_tvalid still high
  task automatic send_item(input logic kind, input logic [7:0] data_byte,
                           input logic [7:0] idx, input logic [CP_W-1:0] val,
                           input logic last_in);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tlast  <= last_in;
    in_tdata  <= {val, idx, data_byte};
    do @(posedge clk); while (!in_tready);
    predict_transcode(kind, data_byte, idx, val, last_in);
    @(negedge clk);
  endtask

  task automatic send_data(input logic [7:0] data_byte, input logic last_in);
    send_item(KIND_DATA, data_byte, 8'($urandom), $urandom, last_in);
  endtask

  task automatic send_table_write(input logic [7:0] idx, input logic [CP_W-1:0] val);
    send_item(KIND_TABLE_WR, 8'($urandom), idx, val, 1'($urandom_range(0, 1)));
  endtask

  // never read a slot that has not been loaded
  task automatic send_mapped_byte(input logic [7:0] data_byte, input logic last_in);
    if (active_mode != MODE_PASS && data_byte[7] && !slot_written[slot_of(data_byte)])
      send_table_write(slot_of(data_byte), pick_point());
    send_data(data_byte, last_in);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (utf8_expected_q.size() != 0) @(negedge clk);
    // a table write may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    drain_results();
    cfg_we      <= 1'b1;
    cfg_wdata   <= m;
    active_mode  = m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_passthrough();
    set_mode(MODE_PASS);
    send_data(8'h00, 1'b0);
    send_data(8'h7F, 1'b1);
    send_data(8'h80, 1'b0);
    send_data(8'hFF, 1'b1);
    send_data(8'hA5, 1'b0);
    send_data(8'h5A, 1'b1);
  endtask

  task automatic test_code_points();
    logic [CP_W-1:0] points [10];
    points = '{32'h0, 32'h41, 32'h80, 32'h7FF, 32'h800, 32'hD800, 32'hFFFF,
               32'h10000, 32'h10FFFF, 32'h110000};
    for (int i = 0; i < 10; i++) send_table_write(8'(i), points[i]);
    set_mode(MODE_PAGE0);
    for (int i = 0; i < 10; i++) send_data({1'b1, i[6:0]}, i[0]);
    send_data(8'h00, 1'b0);
    send_data(8'h7F, 1'b1);
    // second page: top slot holds a low surrogate, bottom slot the largest word
    send_table_write(8'hFF, 32'hDFFF);
    send_table_write(8'h80, 32'hFFFF_FFFF);
    set_mode(MODE_PAGE1);
    send_data(8'hFF, 1'b0);
    send_data(8'h80, 1'b1);
    send_data(8'h41, 1'b0);
    set_mode(MODE_PAGE1_ALT);
    send_data(8'hFF, 1'b0);
    send_data(8'h80, 1'b1);
  endtask

  task automatic test_random_traffic(input int items_per_phase);
    logic [1:0] phase_modes [5];
    phase_modes = '{MODE_PAGE0, MODE_PASS, MODE_PAGE1_ALT, MODE_PAGE1, MODE_PASS};
    phase_modes[4] = 2'($urandom_range(0, 3));
    foreach (phase_modes[p]) begin
      set_mode(phase_modes[p]);
      for (int i = 0; i < items_per_phase; i++) begin
        if (p == 0 && i == items_per_phase / 2) drain_results();
        if ($urandom_range(0, 99) < 15)
          send_table_write(8'($urandom), pick_point());
        else
          send_mapped_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    set_mode(MODE_PAGE0);
    for (int i = 0; i < 30; i++)
      send_mapped_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    drain_results();
    no_gaps = 1'b0;
  endtask

  // receiver back-pressure
  initial begin
    int n;
    forever begin
      @(negedge clk);
      n = gap_len();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // compare each output transaction against the oldest expected byte
  always @(posedge clk) begin
    utf8_byte_t exp_b;
    if (rst_n && out_tvalid && out_tready) begin
      if (utf8_expected_q.size() == 0) begin
        $error("unexpected output byte %02h", out_tdata);
        mismatch_count++;
      end else begin
        exp_b = utf8_expected_q.pop_front();
        if (out_tdata !== exp_b.ubyte) begin
          $error("out_byte: expected %02h, got %02h", exp_b.ubyte, out_tdata);
          mismatch_count++;
        end
        if (out_tlast !== exp_b.run_last) begin
          $error("last: expected %0b, got %0b", exp_b.run_last, out_tlast);
          mismatch_count++;
        end
        if (out_tuser !== exp_b.buf_end) begin
          $error("buffer_end: expected %0b, got %0b", exp_b.buf_end, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("codepage_to_utf8_transcoder: mismatch");
    $finish;
  end

  initial begin
    foreach (slot_written[i]) slot_written[i] = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_passthrough();
    test_code_points();
    test_random_traffic(25);
    test_back_to_back();
    in_tvalid <= 1'b0;
    while (utf8_expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0)
      $display("codepage_to_utf8_transcoder: match");
    else
      $display("codepage_to_utf8_transcoder: mismatch");
    $finish;
  end

endmodule
